[hdl/htfd_pkg.sv]
// ============================================================================
// htfd_pkg
// Shared types and constants for the hub telemetry frame decoder.
// ============================================================================
package htfd_pkg;

    // Default length of the packet store, in bytes.
    localparam int PACKET_BYTES_DEF = 8;
    // Number of closed packets that can wait between the front and back parts.
    localparam int QUEUE_DEPTH      = 4;
    // Only the id byte and the two data bytes of a packet are ever read.
    localparam int STORE_KEEP       = 3;

    localparam int VALUE_W = 34;
    localparam int DEG_W   = 10;
    localparam int UNITS_W = 24;

    localparam logic [7:0] SYNC_BYTE = 8'h5E;

    // Packet ids.
    localparam logic [7:0] ID_VOLTS    = 8'h39;
    localparam logic [7:0] ID_REL_ALT  = 8'h10;
    localparam logic [7:0] ID_MSL_ALT  = 8'h01;
    localparam logic [7:0] ID_HEADING  = 8'h14;
    localparam logic [7:0] ID_ACCEL_X  = 8'h24;
    localparam logic [7:0] ID_ACCEL_Y  = 8'h25;
    localparam logic [7:0] ID_ACCEL_Z  = 8'h26;
    localparam logic [7:0] ID_LON_INT  = 8'h12;
    localparam logic [7:0] ID_LON_FRAC = 8'h1A;
    localparam logic [7:0] ID_LAT_INT  = 8'h13;
    localparam logic [7:0] ID_LAT_FRAC = 8'h1B;
    localparam logic [7:0] ID_SPD_INT  = 8'h11;
    localparam logic [7:0] ID_SPD_FRAC = 8'h19;
    localparam logic [7:0] ID_EW       = 8'h22;
    localparam logic [7:0] ID_NS       = 8'h23;

    localparam logic [7:0] LETTER_E = 8'h45;
    localparam logic [7:0] LETTER_N = 8'h4E;

    localparam logic [UNITS_W-1:0] SAT24 = 24'hFFFFFF;

    // floor(d / 100) = (d * RECIP_100) >> 24 for any 16-bit d.
    localparam logic [17:0] RECIP_100     = 18'd167773;
    localparam logic [13:0] MINUTE_SCALE  = 14'd10000;
    localparam logic [23:0] DEG_SCALE     = 24'd10000000;
    // floor(t / 3) = (t * RECIP_3) >> 33 for any t below 2^32.
    localparam logic [31:0] RECIP_3       = 32'hAAAAAAAB;
    // km/h = floor(knots_hundredths * 463 / 25000); 25000 = 8 * 3125.
    localparam logic [8:0]  KNOT_NUM      = 9'd463;
    // floor(y / 3125) = (y * RECIP_3125) >> 42 for any y below 2^30.
    localparam logic [30:0] RECIP_3125    = 31'd1407374884;

    typedef enum logic [3:0] {
        Q_NONE    = 4'd0,
        Q_VOLTS   = 4'd1,
        Q_REL_ALT = 4'd2,
        Q_MSL_ALT = 4'd3,
        Q_LON     = 4'd4,
        Q_LAT     = 4'd5,
        Q_HEADING = 4'd6,
        Q_SPEED   = 4'd7,
        Q_ACC_X   = 4'd8,
        Q_ACC_Y   = 4'd9,
        Q_ACC_Z   = 4'd10
    } t_qty;

    // One closed packet as handed from the front part to the back part.
    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] data;
    } t_pkt;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[hdl/htfd_front.sv]
// ============================================================================
// htfd_front
// Byte framing: sync hunting, packet store filling and packet closing.
// ============================================================================
module htfd_front
    import htfd_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_push,
    output t_pkt       o_pkt
);

    localparam int FILL_W = $clog2(PACKET_BYTES + 1);

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_ONE   = 2'd1,
        PH_ARMED = 2'd2
    } t_phase;

    t_phase            r_phase;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_store [STORE_KEEP];

    logic is_sync;

    assign is_sync = (i_byte == SYNC_BYTE);

    // A sync byte while armed closes the packet held in the store.
    assign o_push = i_accept && (r_phase == PH_ARMED) && is_sync;
    assign o_pkt  = '{id: r_store[0], data: {r_store[2], r_store[1]}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_fill  <= '0;
            for (int k = 0; k < STORE_KEEP; k++) begin
                r_store[k] <= '0;
            end
        end else if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (is_sync) begin
                        r_phase <= PH_ONE;
                    end
                end
                PH_ONE: begin
                    r_phase <= is_sync ? PH_ARMED : PH_HUNT;
                end
                PH_ARMED: begin
                    if (is_sync) begin
                        r_fill <= '0;
                    end else if (r_fill >= FILL_W'(PACKET_BYTES)) begin
                        // Store overflow drops the byte and goes back to hunting.
                        r_fill  <= '0;
                        r_phase <= PH_HUNT;
                    end else begin
                        for (int k = 0; k < STORE_KEEP; k++) begin
                            if (r_fill == FILL_W'(k)) begin
                                r_store[k] <= i_byte;
                            end
                        end
                        r_fill <= r_fill + 1'b1;
                    end
                end
                default: begin
                    r_phase <= PH_HUNT;
                end
            endcase
        end
    end

endmodule

[hdl/htfd_queue.sv]
// ============================================================================
// htfd_queue
// Small first-in first-out queue of closed packets.
// ============================================================================
module htfd_queue
    import htfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pkt    i_pkt,
    input  logic    i_pop,
    output t_pkt    o_pkt,
    output t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pkt             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_pkt        = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_pkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hdl/htfd_back.sv]
// ============================================================================
// htfd_back
// Packet decode pipeline: position and speed state, scaling and result.
// ============================================================================
module htfd_back
    import htfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_pkt               i_pkt,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output t_qty               o_qty,
    output logic [VALUE_W-1:0] o_value,
    output t_pkt               o_pkt
);

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PLAIN,
        OP_LON_INT,
        OP_LON_FRAC,
        OP_LAT_INT,
        OP_LAT_FRAC,
        OP_SPD_INT,
        OP_SPD_FRAC,
        OP_EW,
        OP_NS
    } t_op;

    // The whole pipeline moves together while the output register can take.
    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    // ---------------- stage 0: classify, divide by 100 -----------------
    logic        r0_v;
    t_pkt        r0_pkt;
    t_op         r0_op;
    t_qty        r0_qty;
    logic [DEG_W-1:0] r0_q100;

    t_op         n0_op;
    t_qty        n0_qty;
    logic [33:0] w_prod100;

    assign w_prod100 = 34'(i_pkt.data) * 34'(RECIP_100);

    always_comb begin
        n0_op  = OP_PLAIN;
        n0_qty = Q_NONE;
        case (i_pkt.id)
            ID_VOLTS:    n0_qty = Q_VOLTS;
            ID_REL_ALT:  n0_qty = Q_REL_ALT;
            ID_MSL_ALT:  n0_qty = Q_MSL_ALT;
            ID_HEADING:  n0_qty = Q_HEADING;
            ID_ACCEL_X:  n0_qty = Q_ACC_X;
            ID_ACCEL_Y:  n0_qty = Q_ACC_Y;
            ID_ACCEL_Z:  n0_qty = Q_ACC_Z;
            ID_LON_INT:  begin n0_op = OP_LON_INT;  n0_qty = Q_LON;   end
            ID_LON_FRAC: begin n0_op = OP_LON_FRAC; n0_qty = Q_LON;   end
            ID_LAT_INT:  begin n0_op = OP_LAT_INT;  n0_qty = Q_LAT;   end
            ID_LAT_FRAC: begin n0_op = OP_LAT_FRAC; n0_qty = Q_LAT;   end
            ID_SPD_INT:  begin n0_op = OP_SPD_INT;  n0_qty = Q_SPEED; end
            ID_SPD_FRAC: begin n0_op = OP_SPD_FRAC; n0_qty = Q_SPEED; end
            ID_EW:       n0_op = OP_EW;
            ID_NS:       n0_op = OP_NS;
            default:     n0_op = OP_NONE;
        endcase
    end

    // ---------------- stage 1: remainder, speed integer part -----------
    logic        r1_v;
    t_pkt        r1_pkt;
    t_op         r1_op;
    t_qty        r1_qty;
    logic [DEG_W-1:0]   r1_deg;
    logic [6:0]         r1_rem;
    logic [UNITS_W-1:0] r1_spd0;
    logic [15:0]        w_rem16;

    assign w_rem16 = r0_pkt.data - 16'(16'(r0_q100) * 16'd100);

    // ---------------- stage 2: minute units of the integer part --------
    logic        r2_v;
    t_pkt        r2_pkt;
    t_op         r2_op;
    t_qty        r2_qty;
    logic [DEG_W-1:0]   r2_deg;
    logic [UNITS_W-1:0] r2_units0;
    logic [UNITS_W-1:0] r2_spd0;

    // ---------------- stage 3: kept state ------------------------------
    logic [DEG_W-1:0]   r_lon_deg;
    logic [UNITS_W-1:0] r_lon_units;
    logic [DEG_W-1:0]   r_lat_deg;
    logic [UNITS_W-1:0] r_lat_units;
    logic [UNITS_W-1:0] r_speed;
    logic [7:0]         r_ew;
    logic [7:0]         r_ns;

    logic        r3_v;
    t_pkt        r3_pkt;
    t_op         r3_op;
    t_qty        r3_qty;
    logic [DEG_W-1:0]   r3_deg;
    logic [UNITS_W-1:0] r3_units;
    logic [UNITS_W-1:0] r3_speed;
    logic               r3_pos;

    logic [UNITS_W:0]   w_lon_sum;
    logic [UNITS_W:0]   w_lat_sum;
    logic [UNITS_W:0]   w_spd_sum;
    logic [UNITS_W-1:0] w_lon_sat;
    logic [UNITS_W-1:0] w_lat_sat;
    logic [UNITS_W-1:0] w_spd_sat;

    assign w_lon_sum = {1'b0, r_lon_units} + (UNITS_W + 1)'(r2_pkt.data);
    assign w_lat_sum = {1'b0, r_lat_units} + (UNITS_W + 1)'(r2_pkt.data);
    assign w_spd_sum = {1'b0, r_speed} + (UNITS_W + 1)'(r2_pkt.data);
    assign w_lon_sat = w_lon_sum[UNITS_W] ? SAT24 : w_lon_sum[UNITS_W-1:0];
    assign w_lat_sat = w_lat_sum[UNITS_W] ? SAT24 : w_lat_sum[UNITS_W-1:0];
    assign w_spd_sat = w_spd_sum[UNITS_W] ? SAT24 : w_spd_sum[UNITS_W-1:0];

    // ---------------- stage 4: scale to fixed point --------------------
    logic        r4_v;
    t_pkt        r4_pkt;
    t_op         r4_op;
    t_qty        r4_qty;
    logic [VALUE_W-1:0] r4_degpart;
    logic [30:0]        r4_t;
    logic [32:0]        r4_sp;
    logic               r4_pos;

    // ---------------- stage 5: reciprocal divides ----------------------
    logic        r5_v;
    t_pkt        r5_pkt;
    t_op         r5_op;
    t_qty        r5_qty;
    logic [VALUE_W-1:0] r5_degpart;
    logic [29:0]        r5_quo3;
    logic [18:0]        r5_kmh;
    logic               r5_pos;

    logic [62:0] w_prod3;
    logic [60:0] w_prod3125;

    assign w_prod3    = 63'(r4_t) * 63'(RECIP_3);
    assign w_prod3125 = 61'(r4_sp[32:3]) * 61'(RECIP_3125);

    // ---------------- stage 6: result register -------------------------
    logic [VALUE_W-1:0] w_mag;
    logic [VALUE_W-1:0] n_value;

    assign w_mag = r5_degpart + VALUE_W'(r5_quo3);

    always_comb begin
        case (r5_op)
            OP_PLAIN: n_value = VALUE_W'(r5_pkt.data);
            OP_LON_INT, OP_LON_FRAC, OP_LAT_INT, OP_LAT_FRAC:
                n_value = r5_pos ? w_mag : -w_mag;
            OP_SPD_INT, OP_SPD_FRAC: n_value = VALUE_W'(r5_kmh);
            default: n_value = '0;
        endcase
    end

    // Valid bits and kept state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v        <= 1'b0;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            o_valid     <= 1'b0;
            r_lon_deg   <= '0;
            r_lon_units <= '0;
            r_lat_deg   <= '0;
            r_lat_units <= '0;
            r_speed     <= '0;
            r_ew        <= '0;
            r_ns        <= '0;
        end else if (en) begin
            r0_v    <= i_valid;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            o_valid <= r5_v;
            if (r2_v) begin
                case (r2_op)
                    OP_LON_INT: begin
                        r_lon_deg   <= r2_deg;
                        r_lon_units <= r2_units0;
                    end
                    OP_LON_FRAC: r_lon_units <= w_lon_sat;
                    OP_LAT_INT: begin
                        r_lat_deg   <= r2_deg;
                        r_lat_units <= r2_units0;
                    end
                    OP_LAT_FRAC: r_lat_units <= w_lat_sat;
                    OP_SPD_INT:  r_speed <= r2_spd0;
                    OP_SPD_FRAC: r_speed <= w_spd_sat;
                    OP_EW:       r_ew <= r2_pkt.data[7:0];
                    OP_NS:       r_ns <= r2_pkt.data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload of every stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_pkt  <= i_pkt;
            r0_op   <= n0_op;
            r0_qty  <= n0_qty;
            r0_q100 <= w_prod100[33:24];

            r1_pkt  <= r0_pkt;
            r1_op   <= r0_op;
            r1_qty  <= r0_qty;
            r1_deg  <= r0_q100;
            r1_rem  <= w_rem16[6:0];
            r1_spd0 <= UNITS_W'(r0_pkt.data) * UNITS_W'(100);

            r2_pkt    <= r1_pkt;
            r2_op     <= r1_op;
            r2_qty    <= r1_qty;
            r2_deg    <= r1_deg;
            r2_units0 <= UNITS_W'(r1_rem) * UNITS_W'(MINUTE_SCALE);
            r2_spd0   <= r1_spd0;

            r3_pkt <= r2_pkt;
            r3_op  <= r2_op;
            r3_qty <= r2_qty;
            case (r2_op)
                OP_LON_INT: begin
                    r3_deg   <= r2_deg;
                    r3_units <= r2_units0;
                end
                OP_LON_FRAC: begin
                    r3_deg   <= r_lon_deg;
                    r3_units <= w_lon_sat;
                end
                OP_LAT_INT: begin
                    r3_deg   <= r2_deg;
                    r3_units <= r2_units0;
                end
                OP_LAT_FRAC: begin
                    r3_deg   <= r_lat_deg;
                    r3_units <= w_lat_sat;
                end
                default: begin
                    r3_deg   <= r2_deg;
                    r3_units <= r2_units0;
                end
            endcase
            r3_speed <= (r2_op == OP_SPD_INT) ? r2_spd0 : w_spd_sat;
            r3_pos   <= (r2_op == OP_LAT_INT || r2_op == OP_LAT_FRAC) ?
                        (r_ns == LETTER_N) : (r_ew == LETTER_E);

            r4_pkt     <= r3_pkt;
            r4_op      <= r3_op;
            r4_qty     <= r3_qty;
            r4_degpart <= VALUE_W'(r3_deg) * VALUE_W'(DEG_SCALE);
            r4_t       <= 31'(r3_units) * 31'd50 + 31'd1;
            r4_sp      <= 33'(r3_speed) * 33'(KNOT_NUM);
            r4_pos     <= r3_pos;

            r5_pkt     <= r4_pkt;
            r5_op      <= r4_op;
            r5_qty     <= r4_qty;
            r5_degpart <= r4_degpart;
            r5_quo3    <= w_prod3[62:33];
            r5_kmh     <= w_prod3125[60:42];
            r5_pos     <= r4_pos;

            o_pkt   <= r5_pkt;
            o_qty   <= r5_qty;
            o_value <= n_value;
        end
    end

endmodule

[hdl/hub_telemetry_frame_decoder.sv]
// ============================================================================
// hub_telemetry_frame_decoder
// Hub telemetry byte stream decoder with position and speed scaling.
// ============================================================================
//
//  Channel   Direction  Payload (lowest bit first)
//  --------  ---------  ------------------------------------------------------
//  s_axis    in         tdata[7:0]   rx_byte
//  m_axis    out        tdata[3:0]   quantity, [37:4] value (signed),
//                       [45:38] packet_id, [61:46] packet_data, [63:62] zero
//
//  One byte is taken in every cycle while the queue has room. A closing
//  sync byte gives its result after passing the packet queue and then the
//  decode pipeline, whose kept position and speed state sits in a single
//  stage so that consecutive packets chain without bubbles.
//  Reset is synchronous and active low; it clears framing, the store and
//  all kept state. A stalled output freezes the decode pipeline; bytes keep
//  flowing until four closed packets wait in the queue.
//
module hub_telemetry_frame_decoder
    import htfd_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // quantity, value, packet_id, packet_data
);

    // The front part sees every accepted byte; the queue holds closed packets.
    logic    in_accept;
    logic    front_push;
    t_pkt    front_pkt;
    t_pkt    q_pkt;
    t_q_stat q_stat;
    logic    back_pop;

    t_qty               out_qty;
    logic [VALUE_W-1:0] out_value;
    t_pkt               out_pkt;

    // Bytes are refused only while the queue is full, since any byte may close a packet.
    assign s_axis_tready = !q_stat.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    htfd_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .o_push   (front_push),
        .o_pkt    (front_pkt)
    );

    htfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pkt   (front_pkt),
        .i_pop   (back_pop),
        .o_pkt   (q_pkt),
        .o_stat  (q_stat)
    );

    // The back part owns the output register; one packet per cycle unless stalled.
    htfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_stat.empty),
        .i_pkt   (q_pkt),
        .o_pop   (back_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_qty   (out_qty),
        .o_value (out_value),
        .o_pkt   (out_pkt)
    );

    assign m_axis_tdata = {2'b00, out_pkt.data, out_pkt.id, out_value, out_qty};

    // Reset leaves no result pending and no packet queued.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && q_stat.empty))
        else $error("result or packet left over after reset");

    // A closed packet lands in the queue; it cannot be lost on the way.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |=> !q_stat.empty)
        else $error("closed packet did not reach the queue");

    // The front part never closes a packet into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> !q_stat.full)
        else $error("packet pushed into a full queue");

    // Only defined quantity codes leave the block.
    a_qty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= Q_ACC_Z))
        else $error("undefined quantity code on output");

endmodule

[tb/sv/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the hub telemetry frame decoder: a short table of
// framing corner cases, then framed packets with random content and noise,
// all checked against a cycle-free decode tracker.
// ============================================================================
module tb_top;
    import htfd_pkg::*;

    // Framing phases of the tracker, as the decoder walks them.
    localparam logic [1:0] HUNT  = 2'd0;
    localparam logic [1:0] HALF  = 2'd1;
    localparam logic [1:0] ARMED = 2'd2;

    // An id that the decoder has no quantity for, named because it is a
    // known telemetry id that this block deliberately leaves out.
    localparam logic [7:0] ID_UNMAPPED = 8'h21;

    // The decoder is built with its default store length.
    localparam int STORE_LEN = PACKET_BYTES_DEF;

    // Number of fractional speed packets sent from the largest whole-knot
    // value; the knots counter saturates on the 157th of them.
    localparam int SPEED_SAT_RUN = 158;

    typedef struct packed {
        t_qty               qty;
        logic signed [33:0] value;
        logic [7:0]         id;
        logic [15:0]        data;
    } t_result;

    typedef struct packed {
        logic [7:0] rx;
        bit         typed;
        t_result    res;
    } t_dir_row;

    localparam t_result NO_RES = '0;

    // Directed stimulus. Rows with the typed flag carry an expectation that
    // is obvious from the framing rules; every other result row is left to
    // the tracker.
    localparam t_dir_row DIR_TAB [28] = '{
        // Two sync bytes arm framing; a third closes an empty packet, which
        // reads the store as reset left it.
        '{8'h5E, 1'b0, NO_RES},
        '{8'h5E, 1'b0, NO_RES},
        '{8'h5E, 1'b1, t_result'{Q_NONE, 34'sd0, 8'h00, 16'h0000}},
        // A plain voltage packet.
        '{ID_VOLTS, 1'b0, NO_RES},
        '{8'h34, 1'b0, NO_RES},
        '{8'h12, 1'b0, NO_RES},
        '{8'h5E, 1'b1, t_result'{Q_VOLTS, 34'sd4660, ID_VOLTS, 16'h1234}},
        // Eight bytes fill the store, the ninth overflows it and framing
        // drops back to hunting without a result.
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        // A single sync byte followed by data breaks the sync.
        '{8'h5E, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES},
        // Re-arm and close at once: the stale store gives the largest id and
        // data word, an id with no quantity.
        '{8'h5E, 1'b0, NO_RES},
        '{8'h5E, 1'b0, NO_RES},
        '{8'h5E, 1'b1, t_result'{Q_NONE, 34'sd0, 8'hFF, 16'hFFFF}},
        // Largest whole longitude while the hemisphere is still west.
        '{ID_LON_INT, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'h5E, 1'b0, NO_RES},
        // Short packet setting the east letter; its high data byte is stale.
        '{ID_EW, 1'b0, NO_RES},
        '{LETTER_E, 1'b0, NO_RES},
        '{8'h5E, 1'b1, t_result'{Q_NONE, 34'sd0, ID_EW, 16'hFF45}}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;            // [3:0] quantity, [37:4] value,
                                          // [45:38] packet_id, [61:46] packet_data

    hub_telemetry_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // Tracker state: a copy of everything the decoder keeps between bytes.
    logic [1:0]  trk_phase = HUNT;
    logic [7:0]  trk_store [STORE_LEN] = '{default: 8'h00};
    int          trk_fill  = 0;
    logic [7:0]  ew_letter = 8'h00;
    logic [7:0]  ns_letter = 8'h00;
    logic [9:0]  lon_deg   = '0;
    logic [23:0] lon_units = '0;
    logic [9:0]  lat_deg   = '0;
    logic [23:0] lat_units = '0;
    logic [23:0] spd_hk    = '0;

    // Results that the decoder still owes, oldest first.
    t_result     decoded_q [$];
    int          error_count = 0;
    int          armed_items = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + b;
        return s[24] ? SAT24 : s[23:0];
    endfunction

    // Degrees plus 1e-4 minute units, turned into signed 1e-7 degree units.
    // Units times 50/3 is rounded to nearest.
    function automatic logic signed [33:0] geo_value(input logic [9:0] deg,
                                                     input logic [23:0] units,
                                                     input bit positive);
        logic [63:0] mag;
        mag = 64'(deg) * 64'd10000000 + (64'(units) * 64'd50 + 64'd1) / 64'd3;
        if (!positive) mag = -mag;
        return mag[33:0];
    endfunction

    function automatic logic signed [33:0] speed_kmh();
        logic [63:0] t;
        t = 64'(spd_hk) * 64'd1852 / 64'd100000;
        return t[33:0];
    endfunction

    // Advances the tracker by one byte. Returns 1 when the byte closes a
    // packet, with the decoded result in r.
    function automatic bit track_byte(input logic [7:0] rx, output t_result r);
        logic [7:0]  pid;
        logic [15:0] d;
        r = '0;
        case (trk_phase)
            HUNT: begin
                if (rx == SYNC_BYTE) trk_phase = HALF;
                return 1'b0;
            end
            HALF: begin
                trk_phase = (rx == SYNC_BYTE) ? ARMED : HUNT;
                return 1'b0;
            end
            ARMED: ;
            default: begin
                trk_phase = HUNT;
                return 1'b0;
            end
        endcase
        if (rx != SYNC_BYTE) begin
            // A full store makes the next data byte drop framing.
            if (trk_fill >= STORE_LEN) begin
                trk_fill  = 0;
                trk_phase = HUNT;
            end else begin
                trk_store[trk_fill] = rx;
                trk_fill++;
            end
            return 1'b0;
        end
        trk_fill = 0;
        pid      = trk_store[0];
        d        = {trk_store[2], trk_store[1]};
        r.id     = pid;
        r.data   = d;
        r.qty    = Q_NONE;
        r.value  = '0;
        case (pid)
            ID_VOLTS:   begin r.qty = Q_VOLTS;   r.value = 34'(d); end
            ID_REL_ALT: begin r.qty = Q_REL_ALT; r.value = 34'(d); end
            ID_MSL_ALT: begin r.qty = Q_MSL_ALT; r.value = 34'(d); end
            ID_HEADING: begin r.qty = Q_HEADING; r.value = 34'(d); end
            ID_ACCEL_X: begin r.qty = Q_ACC_X;   r.value = 34'(d); end
            ID_ACCEL_Y: begin r.qty = Q_ACC_Y;   r.value = 34'(d); end
            ID_ACCEL_Z: begin r.qty = Q_ACC_Z;   r.value = 34'(d); end
            ID_LON_INT: begin
                lon_deg   = 10'(d / 16'd100);
                lon_units = 24'((d % 16'd100) * 32'd10000);
                r.qty     = Q_LON;
                r.value   = geo_value(lon_deg, lon_units, ew_letter == LETTER_E);
            end
            ID_LON_FRAC: begin
                lon_units = sat_add24(lon_units, d);
                r.qty     = Q_LON;
                r.value   = geo_value(lon_deg, lon_units, ew_letter == LETTER_E);
            end
            ID_LAT_INT: begin
                lat_deg   = 10'(d / 16'd100);
                lat_units = 24'((d % 16'd100) * 32'd10000);
                r.qty     = Q_LAT;
                r.value   = geo_value(lat_deg, lat_units, ns_letter == LETTER_N);
            end
            ID_LAT_FRAC: begin
                lat_units = sat_add24(lat_units, d);
                r.qty     = Q_LAT;
                r.value   = geo_value(lat_deg, lat_units, ns_letter == LETTER_N);
            end
            ID_SPD_INT: begin
                spd_hk  = 24'(d * 32'd100);
                r.qty   = Q_SPEED;
                r.value = speed_kmh();
            end
            ID_SPD_FRAC: begin
                spd_hk  = sat_add24(spd_hk, d);
                r.qty   = Q_SPEED;
                r.value = speed_kmh();
            end
            ID_EW: ew_letter = d[7:0];
            ID_NS: ns_letter = d[7:0];
            default: ;
        endcase
        return 1'b1;
    endfunction

    // Offers one item on the input side, with random idle cycles ahead of
    // it, and records what the decoder owes once the item is taken.
    task automatic send_byte(input logic [7:0] rx, input bit typed = 1'b0,
                             input t_result typed_res = '0);
        t_result r;
        bit      has_res;
        bit      was_armed;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        was_armed = (trk_phase == ARMED);
        has_res   = track_byte(rx, r);
        if (has_res) decoded_q.push_back(typed ? typed_res : r);
        if (was_armed) armed_items++;
    endtask

    // Holds the input side off until every owed result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_data_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == SYNC_BYTE) ? ~b : b;
    endfunction

    function automatic logic [7:0] pick_id();
        case ($urandom_range(0, 16))
            0:  return ID_VOLTS;
            1:  return ID_REL_ALT;
            2:  return ID_MSL_ALT;
            3:  return ID_HEADING;
            4:  return ID_ACCEL_X;
            5:  return ID_ACCEL_Y;
            6:  return ID_ACCEL_Z;
            7:  return ID_LON_INT;
            8:  return ID_LON_FRAC;
            9:  return ID_LAT_INT;
            10: return ID_LAT_FRAC;
            11: return ID_SPD_INT;
            12: return ID_SPD_FRAC;
            13: return ID_EW;
            14: return ID_NS;
            15: return ID_UNMAPPED;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Data words lean toward the ends of the range; hemisphere packets
    // carry the positive letter half of the time.
    function automatic logic [15:0] pick_data(input logic [7:0] pid);
        logic [15:0] d;
        case ($urandom_range(0, 5))
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            2:       d = 16'($urandom_range(0, 255));
            default: d = 16'($urandom_range(0, 65535));
        endcase
        if (pid == ID_EW && $urandom_range(0, 1)) d[7:0] = LETTER_E;
        if (pid == ID_NS && $urandom_range(0, 1)) d[7:0] = LETTER_N;
        return d;
    endfunction

    task automatic arm_framing();
        while (trk_phase != ARMED) send_byte(SYNC_BYTE);
    endtask

    // A well-formed packet: id, two data bytes, optional trailing bytes that
    // the decoder counts but does not keep, then the closing sync byte. A data
    // byte that happens to equal the sync byte closes the packet early.
    task automatic send_packet(input logic [7:0] pid, input logic [15:0] d,
                               input int trail);
        arm_framing();
        send_byte(pid);
        send_byte(d[7:0]);
        send_byte(d[15:8]);
        repeat (trail) send_byte(rand_data_byte());
        send_byte(SYNC_BYTE);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            1: begin
                // Short packet: fewer than three bytes before the close.
                arm_framing();
                repeat ($urandom_range(0, 2)) send_byte(rand_data_byte());
                send_byte(SYNC_BYTE);
            end
            2: begin
                // Store overflow.
                arm_framing();
                repeat ($urandom_range(STORE_LEN + 1, STORE_LEN + 4))
                    send_byte(rand_data_byte());
            end
            default: begin
                // Fall out of framing, then break a fresh sync attempt.
                while (trk_phase != HUNT) send_byte(rand_data_byte());
                send_byte(SYNC_BYTE);
                send_byte(rand_data_byte());
            end
        endcase
    endtask

    task automatic run_random(input int n_items);
        int target;
        logic [7:0] pid;
        target = armed_items + n_items;
        while (armed_items < target) begin
            if ($urandom_range(0, 99) < 15) begin
                send_noise();
            end else begin
                pid = pick_id();
                send_packet(pid, pick_data(pid), $urandom_range(0, STORE_LEN - 3));
            end
            if ($urandom_range(0, 149) == 0) drain();
        end
    endtask

    // Output side: random stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Result checker. Sampled at the edge, so it sees the values that the
    // edge itself saw.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.qty   = t_qty'(m_axis_tdata[3:0]);
            got.value = m_axis_tdata[37:4];
            got.id    = m_axis_tdata[45:38];
            got.data  = m_axis_tdata[61:46];
            if (decoded_q.size() == 0) begin
                $error("result with none owed: quantity %0d value %0d id %h data %h",
                       got.qty, got.value, got.id, got.data);
                error_count++;
            end else begin
                want = decoded_q.pop_front();
                if (got.qty !== want.qty) begin
                    $error("quantity: expected %0d, got %0d", want.qty, got.qty);
                    error_count++;
                end
                if (got.value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, got.value);
                    error_count++;
                end
                if (got.id !== want.id) begin
                    $error("packet_id: expected %h, got %h", want.id, got.id);
                    error_count++;
                end
                if (got.data !== want.data) begin
                    $error("packet_data: expected %h, got %h", want.data, got.data);
                    error_count++;
                end
                if (m_axis_tdata[63:62] !== 2'b00) begin
                    $error("pad: expected 0, got %b", m_axis_tdata[63:62]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender sparse idling, receiver heavy stalls.
        tx_idle_pct = 12;
        rx_idle_pct = 64;
        for (int i = 0; i < $size(DIR_TAB); i++) begin
            send_byte(DIR_TAB[i].rx, DIR_TAB[i].typed, DIR_TAB[i].res);
        end
        run_random(350);
        drain();

        // Sender heavy idling, receiver light stalls.
        tx_idle_pct = 64;
        rx_idle_pct = 12;
        run_random(350);
        drain();

        // Full rate both ways. The speed run first pushes the knots counter
        // into saturation, then random traffic finishes the run.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_packet(ID_SPD_INT, 16'hFFFF, 0);
        repeat (SPEED_SAT_RUN) send_packet(ID_SPD_FRAC, 16'hFFFF, 0);
        run_random(100);

        drain();
        // Keep the clock running past the end of the pipeline to catch strays.
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
